>>> design/led_chain_frame_sender_assert.svh
// ----------------------------------------------------------------------------
// LED chain frame sender: assertion macros
// Shared property wrappers used by the checker of the frame sender.
// ----------------------------------------------------------------------------
`ifndef LED_CHAIN_FRAME_SENDER_ASSERT_SVH
`define LED_CHAIN_FRAME_SENDER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LCFS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("frame sender assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LCFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("frame sender assertion failed");

`endif

>>> design/lcfs_pkg.sv
// ----------------------------------------------------------------------------
// LED chain frame sender package
// Payload types, controller/datapath interface types and the LED word format.
// ----------------------------------------------------------------------------
`default_nettype none

package lcfs_pkg;

  // chain_length register
  localparam int unsigned CfgW = 6;
  localparam logic [CfgW-1:0] ChainLenRst = 6'd32;

  // LED word prefix: two fixed ones in the top bits
  localparam logic [7:0] PrefixBase = 8'hC0;
  localparam logic [31:0] ZeroWord = 32'h0000_0000;

  typedef struct packed {
    logic [7:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [31:0] frame_word;
    logic        last_word;
  } out_item_t;

  // which word the output shows
  typedef enum logic [1:0] {
    SEL_START,
    SEL_LED,
    SEL_END
  } sel_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_LEDS,
    ST_END
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic ptr_clr;
    logic ptr_inc;
    sel_e sel;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic len_zero;
    logic ptr_last;
  } status_t;

  // {red, green, blue} -> {prefix, blue, green, red}
  function automatic logic [31:0] led_word(input logic [23:0] rgb);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] prefix;
    r = rgb[23:16];
    g = rgb[15:8];
    b = rgb[7:0];
    prefix = PrefixBase | {2'b00, ~b[7:6], ~g[7:6], ~r[7:6]};
    return {prefix, b, g, r};
  endfunction

endpackage

`default_nettype wire

>>> design/lcfs_ctrl.sv
// ----------------------------------------------------------------------------
// LED chain frame sender: controller
// Sequences accept, start word, LED words and end word of one frame.
// ----------------------------------------------------------------------------
`default_nettype none

module lcfs_ctrl
  import lcfs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output cmd_t    cmd_o,
  input  status_t status_i
);

  state_e state_q, state_d;
  logic   take;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o.accept  = 1'b0;
    cmd_o.ptr_clr = 1'b0;
    cmd_o.ptr_inc = 1'b0;
    cmd_o.sel     = SEL_START;
    in_stall_o    = 1'b1;
    out_valid_o   = 1'b1;
    take          = !out_stall_i;
    case (state_q)
      ST_IDLE: begin
        in_stall_o  = 1'b0;
        out_valid_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept  = 1'b1;
          cmd_o.ptr_clr = 1'b1;
          state_d       = ST_START;
        end
      end
      ST_START: begin
        cmd_o.sel = SEL_START;
        if (take) begin
          state_d = status_i.len_zero ? ST_END : ST_LEDS;
        end
      end
      ST_LEDS: begin
        cmd_o.sel = SEL_LED;
        if (take) begin
          if (status_i.ptr_last) begin
            state_d = ST_END;
          end else begin
            cmd_o.ptr_inc = 1'b1;
          end
        end
      end
      ST_END: begin
        cmd_o.sel = SEL_END;
        if (take) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> design/lcfs_datapath.sv
// ----------------------------------------------------------------------------
// LED chain frame sender: datapath
// Color store, chain length register, read pointer and output word mux.
// ----------------------------------------------------------------------------
`default_nettype none

module lcfs_datapath
  import lcfs_pkg::*;
#(
  parameter int unsigned MAX_LEDS = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_wr_en_i,
  input  logic [CfgW-1:0] cfg_wr_data_i,
  input  in_item_t        in_item_i,
  input  cmd_t            cmd_i,
  output status_t         status_o,
  output out_item_t       out_item_o
);

  localparam int unsigned IdxW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam logic [CfgW-1:0] MaxLen = CfgW'(MAX_LEDS);

  logic [CfgW-1:0] chain_len_q;
  logic [CfgW-1:0] len_eff;
  logic [CfgW-1:0] len_q;
  logic [IdxW-1:0] ptr_q, ptr_d;
  logic [MAX_LEDS-1:0] valid_q;
  logic [23:0]     mem [MAX_LEDS];
  logic [23:0]     rdata_q;
  logic            rvalid_q;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;

  // chain length register, saturated to the store depth
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_len_q <= ChainLenRst;
    end else if (cfg_wr_en_i) begin
      chain_len_q <= cfg_wr_data_i;
    end
  end

  assign len_eff = (chain_len_q > MaxLen) ? MaxLen : chain_len_q;
  assign wr_en   = cmd_i.accept && (in_item_i.led_index < {2'b00, len_eff});
  assign wr_addr = in_item_i.led_index[IdxW-1:0];

  // read pointer; the store is read at its next value so rdata_q tracks ptr_q
  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.ptr_clr) begin
      ptr_d = '0;
    end else if (cmd_i.ptr_inc) begin
      ptr_d = ptr_q + IdxW'(1);
    end
  end

  // frame length, pointer and per-entry written flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      ptr_q    <= '0;
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      ptr_q    <= ptr_d;
      rvalid_q <= valid_q[ptr_d];
      if (cmd_i.accept) begin
        len_q <= len_eff;
      end
      if (wr_en) begin
        valid_q[wr_addr] <= 1'b1;
      end
    end
  end

  // color store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= {in_item_i.red, in_item_i.green, in_item_i.blue};
    end
    rdata_q <= mem[ptr_d];
  end

  assign status_o.len_zero = (len_q == '0);
  assign status_o.ptr_last = (CfgW'(ptr_q) == (len_q - CfgW'(1)));

  // output word select; an unwritten entry reads as black
  always_comb begin
    out_item_o.frame_word = ZeroWord;
    out_item_o.last_word  = 1'b0;
    case (cmd_i.sel)
      SEL_START: begin
        out_item_o.frame_word = ZeroWord;
      end
      SEL_LED: begin
        out_item_o.frame_word = led_word(rvalid_q ? rdata_q : 24'h00_0000);
      end
      SEL_END: begin
        out_item_o.last_word = 1'b1;
      end
      default: begin
        out_item_o.frame_word = ZeroWord;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> design/led_chain_frame_sender.sv
// ----------------------------------------------------------------------------
// LED chain frame sender
// Stores one color per LED and emits a full 32-bit word frame per update.
// ----------------------------------------------------------------------------
//  channel | signals                               | beat
//  --------+---------------------------------------+-------------------------------
//  in      | in_valid_i / in_stall_o / in_item_i   | LED index and red, green, blue
//  out     | out_valid_o / out_stall_i / out_item_o| one frame word plus last flag
//  cfg     | cfg_wr_en_i / cfg_wr_data_i           | chain_length, written on enable
//
//  An update first accepts and writes the color store, then emits one word
//  per cycle when not stalled (start, LEDs, end). The color store's single
//  registered read port is read at the next pointer value, so it keeps up.
//  Reset clears the controller and all per-LED written flags, so every LED
//  reads as zero color until written; chain_length resets to 32.
//  A stall on the output holds the current word; input is taken only when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module led_chain_frame_sender
  import lcfs_pkg::*;
#(
  parameter int unsigned MAX_LEDS = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_wr_en_i,
  input  logic [CfgW-1:0] cfg_wr_data_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_item_t        in_item_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_item_t       out_item_o
);

  cmd_t    cmd;
  status_t status;

  // frame sequencer
  lcfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // store and word formatting
  lcfs_datapath #(
    .MAX_LEDS (MAX_LEDS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .in_item_i     (in_item_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_item_o    (out_item_o)
  );

endmodule

`default_nettype wire

>>> design/lcfs_checker.sv
// ----------------------------------------------------------------------------
// LED chain frame sender: port checker
// Frame-level checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "led_chain_frame_sender_assert.svh"

module lcfs_checker
  import lcfs_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  logic in_beat;
  logic out_beat;

  assign in_beat  = in_valid_i && !in_stall_o;
  assign out_beat = out_valid_o && !out_stall_i;

  // a stalled output beat holds
  `LCFS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                    out_valid_o && $stable(out_item_o))

  // input is only taken while no frame is in flight
  `LCFS_ASSERT_NOW(a_in_when_idle, clk_i, rst_ni, in_beat, !out_valid_o)

  // every frame opens with the zero start word
  `LCFS_ASSERT_NEXT(a_start_word, clk_i, rst_ni, in_beat,
                    out_valid_o && (out_item_o.frame_word == ZeroWord) &&
                    !out_item_o.last_word)

  // the end word closes the frame
  `LCFS_ASSERT_NEXT(a_end_idle, clk_i, rst_ni, out_beat && out_item_o.last_word,
                    !out_valid_o)

endmodule

bind led_chain_frame_sender lcfs_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire
